### hdl/olas_pkg.sv
// Shared types and constants for the owned life automaton step block.
// Used by the cell memory, the window unit and the top level; no dependencies.
`default_nettype none

package olas_pkg;

   localparam int unsigned OWNER_W = 2;
   localparam int unsigned OWNER_CODES = 2 ** OWNER_W;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned POS_W = 6;
   localparam int unsigned SIZE_W = 7;
   localparam int unsigned GEN_W = 32;
   localparam int unsigned CSR_IDX_W = 4;

   localparam int unsigned MAX_SIDE_DEFAULT = 64;
   localparam int unsigned MIN_SIDE = 3;
   localparam int unsigned GRID_RESET = 64;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STEP = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 4'd1;

   typedef struct packed {
      logic               alive;
      logic [OWNER_W-1:0] owner;
   } cell_type;

endpackage

`default_nettype wire

### hdl/olas_cell_mem.sv
// Single-port-write, single-port-read cell memory holding both frames.
// Read data is registered. Depends on olas_pkg.
`default_nettype none

module olas_cell_mem #(
   parameter int unsigned ADDR_W = 13
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  olas_pkg::cell_type     wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output olas_pkg::cell_type     rd_data
);

   localparam int unsigned DEPTH = 2 ** ADDR_W;

   olas_pkg::cell_type mem [DEPTH];
   olas_pkg::cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/olas_window.sv
// Two row line buffers, a 3x3 cell window and the life rule for its center.
// Depends on olas_pkg for the cell type.
`default_nettype none

module olas_window #(
   parameter int unsigned MAX_SIDE = olas_pkg::MAX_SIDE_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          shift_en,
   input  olas_pkg::cell_type cell_in,
   input  wire logic          center_interior,
   output olas_pkg::cell_type next_out
);

   localparam int unsigned NBR_W = 4;
   localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [NBR_W-1:0] KEEP_COUNT = 4'd2;

   olas_pkg::cell_type line1_ff [MAX_SIDE];
   olas_pkg::cell_type line2_ff [MAX_SIDE];
   olas_pkg::cell_type win_ff [3][3];

   olas_pkg::cell_type          center;
   logic [NBR_W-1:0]            live_count;
   logic [NBR_W-1:0]            owner_count [olas_pkg::OWNER_CODES];
   logic [olas_pkg::OWNER_W-1:0] winner;

   // Row 0 of the window is the oldest row, column 2 the newest column.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         line1_ff[0] <= cell_in;
         line2_ff[0] <= line1_ff[MAX_SIDE-1];
         for (int i = 1; i < MAX_SIDE; i++) begin
            line1_ff[i] <= line1_ff[i-1];
            line2_ff[i] <= line2_ff[i-1];
         end
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= line2_ff[MAX_SIDE-1];
         win_ff[1][2] <= line1_ff[MAX_SIDE-1];
         win_ff[2][2] <= cell_in;
      end
   end

   always_comb begin
      center = win_ff[1][1];
      live_count = '0;
      for (int o = 0; o < olas_pkg::OWNER_CODES; o++) begin
         owner_count[o] = '0;
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (!(r == 1 && c == 1) && win_ff[r][c].alive) begin
               live_count = live_count + NBR_W'(1);
               owner_count[win_ff[r][c].owner] = owner_count[win_ff[r][c].owner] + NBR_W'(1);
            end
         end
      end
      // Owner zero never wins, so a birth from it keeps the old owner.
      winner = '0;
      for (int o = 1; o < olas_pkg::OWNER_CODES; o++) begin
         if (owner_count[o] >= NBR_W'(2)) begin
            winner = olas_pkg::OWNER_W'(o);
         end
      end

      next_out = center;
      if (!center_interior) begin
         next_out.alive = 1'b0;
      end else if (live_count == BIRTH_COUNT) begin
         if (!center.alive) begin
            next_out.alive = 1'b1;
            if (winner != '0) begin
               next_out.owner = winner;
            end
         end
      end else if (live_count != KEEP_COUNT) begin
         next_out.alive = 1'b0;
      end
   end

endmodule

`default_nettype wire

### hdl/owned_life_automaton_step.sv
// Top level of the owned life automaton step block: sequencer, result buffering
// and grid size registers. Instantiates olas_cell_mem and olas_window; uses olas_pkg.
//
//   Channel | Direction | Handshake         | Payload
//   req_    | in        | req_valid/stall   | kind, col, row, alive_in, owner_in
//   rsp_    | out       | rsp_valid/stall   | alive_out, owner_out, generation
//   csr_    | in        | csr_valid/ready   | index, data (grid_width, grid_height)
//
// After reset a clearing pass zeroes frame 0, one entry a cycle, all 2**(2*ceil(log2(MAX_SIDE)))
// entries (4096 at MAX_SIDE = 64); no transaction is taken on req_ until it ends.
// Write and unused items go straight to the result buffer; reads first pass through ST_READ.
// A step scans the frame one cell per cycle through the single read port.
// A result waits in a buffer stage, so one new item is taken while rsp_ is stalled.
`default_nettype none

module owned_life_automaton_step #(
   parameter int unsigned MAX_SIDE = olas_pkg::MAX_SIDE_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic [olas_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [olas_pkg::POS_W-1:0]     req_col,
   input  wire logic [olas_pkg::POS_W-1:0]     req_row,
   input  wire logic                           req_alive_in,
   input  wire logic [olas_pkg::OWNER_W-1:0]   req_owner_in,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic                           rsp_alive_out,
   output      logic [olas_pkg::OWNER_W-1:0]   rsp_owner_out,
   output      logic [olas_pkg::GEN_W-1:0]     rsp_generation,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [olas_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [olas_pkg::SIZE_W-1:0]    csr_data
);

   localparam int unsigned SIDE_W = $clog2(MAX_SIDE);
   localparam int unsigned ADDR_W = 2 * SIDE_W + 1;
   localparam int unsigned CNT_W = $clog2(MAX_SIDE + 2);
   localparam int unsigned SIDE_CW = $clog2(MAX_SIDE + 1);
   localparam int unsigned CMP_W =
      ((CNT_W > olas_pkg::SIZE_W) ? CNT_W : olas_pkg::SIZE_W) + 1;
   localparam int unsigned SIDE_RESET =
      (olas_pkg::GRID_RESET > MAX_SIDE) ? MAX_SIDE : olas_pkg::GRID_RESET;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   function automatic logic [SIDE_CW-1:0] clamp_side(input logic [olas_pkg::SIZE_W-1:0] v);
      logic [CMP_W-1:0] vx;
      vx = CMP_W'(v);
      if (vx < CMP_W'(olas_pkg::MIN_SIDE)) begin
         return SIDE_CW'(olas_pkg::MIN_SIDE);
      end
      if (vx > CMP_W'(MAX_SIDE)) begin
         return SIDE_CW'(MAX_SIDE);
      end
      return SIDE_CW'(vx);
   endfunction

   function automatic logic is_interior(input logic [CMP_W-1:0] c, input logic [CMP_W-1:0] r,
                                        input logic [SIDE_CW-1:0] gw,
                                        input logic [SIDE_CW-1:0] gh);
      return (c != '0) && (c + CMP_W'(2) <= CMP_W'(gw)) &&
             (r != '0) && (r + CMP_W'(2) <= CMP_W'(gh));
   endfunction

   state_type                    state_ff, state_in;
   logic [2*SIDE_W-1:0]          clear_ff, clear_in;
   logic                         frame_ff, frame_in;
   logic [olas_pkg::GEN_W-1:0]   gen_ff, gen_in;
   logic [SIDE_CW-1:0]           grid_width_ff, grid_width_in;
   logic [SIDE_CW-1:0]           grid_height_ff, grid_height_in;
   logic [CNT_W-1:0]             scan_row_ff, scan_row_in;
   logic [SIDE_W-1:0]            scan_col_ff, scan_col_in;
   logic                         p1_valid_ff, p1_valid_in;
   logic [CNT_W-1:0]             p1_row_ff, p1_row_in;
   logic [SIDE_W-1:0]            p1_col_ff, p1_col_in;
   logic                         p1_int_ff, p1_int_in;
   logic                         rd_range_ff, rd_range_in;
   logic                         p2_valid_ff, p2_valid_in;
   logic [SIDE_W-1:0]            p2_row_ff, p2_row_in;
   logic [SIDE_W-1:0]            p2_col_ff, p2_col_in;
   logic                         p2_int_ff, p2_int_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic                         pend_alive_ff, pend_alive_in;
   logic [olas_pkg::OWNER_W-1:0] pend_owner_ff, pend_owner_in;
   logic [olas_pkg::GEN_W-1:0]   pend_gen_ff, pend_gen_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_alive_ff, rsp_alive_in;
   logic [olas_pkg::OWNER_W-1:0] rsp_owner_ff, rsp_owner_in;
   logic [olas_pkg::GEN_W-1:0]   rsp_gen_ff, rsp_gen_in;

   logic               req_accept;
   logic               req_int;
   logic               req_range;
   logic               scan_int;
   logic               scan_last;
   logic               pend_move;
   logic [CMP_W-1:0]   ctr_row_x;
   logic [SIDE_W-1:0]  ctr_col;
   logic               ctr_ok;
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   olas_pkg::cell_type mem_wr_data;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   olas_pkg::cell_type mem_rd_data;
   olas_pkg::cell_type win_cell;
   olas_pkg::cell_type next_cell;

   olas_cell_mem #(
      .ADDR_W(ADDR_W)
   ) u_cell_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   olas_window #(
      .MAX_SIDE(MAX_SIDE)
   ) u_window (
      .clock          (clock),
      .shift_en       (p1_valid_ff),
      .cell_in        (win_cell),
      .center_interior(p2_int_ff),
      .next_out       (next_cell)
   );

   assign pend_move = pend_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != ST_IDLE) || (pend_valid_ff && !pend_move);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign req_int = is_interior(CMP_W'(req_col), CMP_W'(req_row),
                                grid_width_ff, grid_height_ff);
   assign req_range = (CMP_W'(req_col) < CMP_W'(MAX_SIDE)) &&
                      (CMP_W'(req_row) < CMP_W'(MAX_SIDE));
   assign scan_int = is_interior(CMP_W'(scan_col_ff), CMP_W'(scan_row_ff),
                                 grid_width_ff, grid_height_ff);
   assign scan_last = (scan_row_ff == CNT_W'(MAX_SIDE + 1)) && (scan_col_ff == '0);

   // Cells outside the interior enter the window as dead but keep their owner.
   always_comb begin
      win_cell.alive = mem_rd_data.alive && p1_int_ff;
      win_cell.owner = mem_rd_data.owner;
   end

   // The window center trails the cell just read by one row and one column.
   always_comb begin
      if (p1_col_ff != '0) begin
         ctr_row_x = CMP_W'(p1_row_ff) - CMP_W'(1);
         ctr_col = p1_col_ff - SIDE_W'(1);
         ctr_ok = (p1_row_ff != '0);
      end else begin
         ctr_row_x = CMP_W'(p1_row_ff) - CMP_W'(2);
         ctr_col = SIDE_W'(MAX_SIDE - 1);
         ctr_ok = (p1_row_ff >= CNT_W'(2));
      end
   end

   always_comb begin
      state_in = state_ff;
      clear_in = clear_ff;
      frame_in = frame_ff;
      gen_in = gen_ff;
      grid_width_in = grid_width_ff;
      grid_height_in = grid_height_ff;
      scan_row_in = scan_row_ff;
      scan_col_in = scan_col_ff;
      p1_valid_in = 1'b0;
      p1_row_in = scan_row_ff;
      p1_col_in = scan_col_ff;
      p1_int_in = scan_int;
      rd_range_in = rd_range_ff;
      p2_valid_in = p1_valid_ff && ctr_ok;
      p2_row_in = ctr_row_x[SIDE_W-1:0];
      p2_col_in = ctr_col;
      p2_int_in = is_interior(CMP_W'(ctr_col), ctr_row_x, grid_width_ff, grid_height_ff);
      pend_valid_in = pend_move ? 1'b0 : pend_valid_ff;
      pend_alive_in = pend_alive_ff;
      pend_owner_in = pend_owner_ff;
      pend_gen_in = pend_gen_ff;

      // Reads come from the current frame, step writes go to the other one,
      // so the scan never reads an entry it is writing.
      mem_wr_en = p2_valid_ff;
      mem_wr_addr = {~frame_ff, p2_row_ff, p2_col_ff};
      mem_wr_data = next_cell;
      mem_rd_en = 1'b0;
      mem_rd_addr = {frame_ff, scan_row_ff[SIDE_W-1:0], scan_col_ff};

      if (csr_valid && csr_ready) begin
         if (csr_index == olas_pkg::CSR_GRID_WIDTH) begin
            grid_width_in = clamp_side(csr_data);
         end else if (csr_index == olas_pkg::CSR_GRID_HEIGHT) begin
            grid_height_in = clamp_side(csr_data);
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = {1'b0, clear_ff};
            mem_wr_data = '0;
            clear_in = clear_ff + 1'b1;
            if (&clear_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_kind)
                  olas_pkg::KIND_WRITE: begin
                     mem_wr_en = req_int;
                     mem_wr_addr = {frame_ff, SIDE_W'(req_row), SIDE_W'(req_col)};
                     mem_wr_data.alive = req_alive_in;
                     mem_wr_data.owner = req_owner_in;
                     pend_valid_in = 1'b1;
                     pend_alive_in = 1'b0;
                     pend_owner_in = '0;
                     pend_gen_in = gen_ff;
                  end
                  olas_pkg::KIND_READ: begin
                     mem_rd_en = 1'b1;
                     mem_rd_addr = {frame_ff, SIDE_W'(req_row), SIDE_W'(req_col)};
                     p1_int_in = req_int;
                     rd_range_in = req_range;
                     state_in = ST_READ;
                  end
                  olas_pkg::KIND_STEP: begin
                     scan_row_in = '0;
                     scan_col_in = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     pend_valid_in = 1'b1;
                     pend_alive_in = 1'b0;
                     pend_owner_in = '0;
                     pend_gen_in = gen_ff;
                  end
               endcase
            end
         end
         ST_READ: begin
            pend_valid_in = 1'b1;
            pend_alive_in = mem_rd_data.alive && p1_int_ff;
            pend_owner_in = rd_range_ff ? mem_rd_data.owner : '0;
            pend_gen_in = gen_ff;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            mem_rd_en = 1'b1;
            p1_valid_in = 1'b1;
            if (scan_col_ff == SIDE_W'(MAX_SIDE - 1)) begin
               scan_col_in = '0;
               scan_row_in = scan_row_ff + 1'b1;
            end else begin
               scan_col_in = scan_col_ff + 1'b1;
            end
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (p2_valid_ff && !p1_valid_ff) begin
               frame_in = ~frame_ff;
               gen_in = gen_ff + 1'b1;
               pend_valid_in = 1'b1;
               pend_alive_in = 1'b0;
               pend_owner_in = '0;
               pend_gen_in = gen_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (pend_move) begin
         rsp_valid_in = 1'b1;
         rsp_alive_in = pend_alive_ff;
         rsp_owner_in = pend_owner_ff;
         rsp_gen_in = pend_gen_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_alive_in = rsp_alive_ff;
         rsp_owner_in = rsp_owner_ff;
         rsp_gen_in = rsp_gen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clear_ff <= '0;
         frame_ff <= 1'b0;
         gen_ff <= '0;
         grid_width_ff <= SIDE_CW'(SIDE_RESET);
         grid_height_ff <= SIDE_CW'(SIDE_RESET);
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
         frame_ff <= frame_in;
         gen_ff <= gen_in;
         grid_width_ff <= grid_width_in;
         grid_height_ff <= grid_height_in;
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_row_ff <= scan_row_in;
      scan_col_ff <= scan_col_in;
      p1_row_ff <= p1_row_in;
      p1_col_ff <= p1_col_in;
      p1_int_ff <= p1_int_in;
      rd_range_ff <= rd_range_in;
      p2_row_ff <= p2_row_in;
      p2_col_ff <= p2_col_in;
      p2_int_ff <= p2_int_in;
      pend_alive_ff <= pend_alive_in;
      pend_owner_ff <= pend_owner_in;
      pend_gen_ff <= pend_gen_in;
      rsp_alive_ff <= rsp_alive_in;
      rsp_owner_ff <= rsp_owner_in;
      rsp_gen_ff <= rsp_gen_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_alive_out = rsp_alive_ff;
   assign rsp_owner_out = rsp_owner_ff;
   assign rsp_generation = rsp_gen_ff;

endmodule

`default_nettype wire
